/* rtl/leib_pkg.sv */
// Shared character codes, result codes and control types for the line edit buffer.
`timescale 1ns / 1ps
package leib_pkg;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_DUMP = 8'h10;
  localparam logic [7:0] CH_KILL = 8'h15;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] ST_RX    = 2'd0;
  localparam logic [1:0] ST_CHAR  = 2'd1;
  localparam logic [1:0] ST_EOF   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic start;
    logic finish;
  } leib_cmd_t;

  typedef struct packed {
    logic out_free;
  } leib_sts_t;

endpackage

/* rtl/line_edit_input_buffer.sv */
// An accepted item is registered, and its result is loaded into the output register once
// that register is free. No new item is taken until the last one is finished; the
// registered read of the character ring is why each item passes through an execute state.
// Reset (rst, synchronous): read, commit and edit indices go to zero, output empties.
// The character ring is not cleared; no entry is used before it is written.
`timescale 1ns / 1ps
module line_edit_input_buffer #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] rx_char, [8] read_in_progress, [15:9] zero
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data, [8] wake, [15:9] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // line_end
);

  leib_pkg::leib_cmd_t cmd;
  leib_pkg::leib_sts_t sts;
  logic [7:0] data;
  logic       wake;

  leib_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  leib_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .kind             (s_tuser),
    .rx_char          (s_tdata[7:0]),
    .read_in_progress (s_tdata[8]),
    .m_tready         (m_tready),
    .out_valid        (m_tvalid),
    .status           (m_tuser),
    .data             (data),
    .line_end         (m_tlast),
    .wake             (wake)
  );

  assign m_tdata = {7'b0, wake, data};

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while previous item still in work");

  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result shown without an item in work");

  a_data_only_delivered: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != leib_pkg::ST_CHAR) |-> (!m_tlast && m_tdata[7:0] == 8'h00))
    else $error("data or line end on a result that delivers no character");

  a_wake_only_rx: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != leib_pkg::ST_RX) |-> !m_tdata[8])
    else $error("wake on a read result");
`endif

endmodule

/* rtl/leib_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module leib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/leib_ctrl.sv */
// Controller state machine: accept an item, then finish it once the output register is free.
`timescale 1ns / 1ps
module leib_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  leib_pkg::leib_sts_t sts,
  output leib_pkg::leib_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign s_tready   = (state == S_IDLE);
  assign cmd.start  = s_tvalid && (state == S_IDLE);
  assign cmd.finish = (state == S_EXEC) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/leib_dp.sv */
// Datapath: ring indices, character ring, line editing and the output register.
`timescale 1ns / 1ps
module leib_dp #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  leib_pkg::leib_cmd_t cmd,
  output leib_pkg::leib_sts_t sts,
  input  logic                kind,
  input  logic [7:0]          rx_char,
  input  logic                read_in_progress,
  input  logic                m_tready,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [7:0]          data,
  output logic                line_end,
  output logic                wake
);

  localparam int IW = $clog2(2 * BUFFER_DEPTH);
  localparam int SW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] IDX_LAST   = IW'(2 * BUFFER_DEPTH - 1);
  localparam logic [IW-1:0] DEPTH_I    = IW'(BUFFER_DEPTH);
  localparam logic [IW-1:0] DEPTH_LAST = IW'(BUFFER_DEPTH - 1);
  localparam logic [IW:0]   IDX_MOD_W  = (IW+1)'(2 * BUFFER_DEPTH);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] v);
    return (v == IDX_LAST) ? '0 : v + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] v);
    return (v == '0) ? IDX_LAST : v - IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (t[IW]) t = t + IDX_MOD_W;
    return t[IW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [IW-1:0] v);
    logic [IW-1:0] s;
    s = (v >= DEPTH_I) ? v - DEPTH_I : v;
    return s[SW-1:0];
  endfunction

  logic          kind_q;
  logic [7:0]    char_q;
  logic          prog_q;
  logic [IW-1:0] read_idx, commit_idx, edit_idx;
  logic [IW-1:0] read_idx_next, commit_idx_next, edit_idx_next;
  logic [IW-1:0] fill;
  logic [7:0]    wr_char;
  logic [7:0]    rd_data;
  logic          store;
  logic [1:0]    status_next;
  logic [7:0]    data_next;
  logic          line_end_next;
  logic          wake_next;

  assign sts.out_free = !out_valid || m_tready;

  leib_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.finish && store),
    .wr_addr (slot_of(edit_idx)),
    .wr_data (wr_char),
    .rd_en   (cmd.start),
    .rd_addr (slot_of(read_idx)),
    .rd_data (rd_data)
  );

  always_comb begin
    read_idx_next   = read_idx;
    commit_idx_next = commit_idx;
    edit_idx_next   = edit_idx;
    store           = 1'b0;
    status_next     = leib_pkg::ST_RX;
    data_next       = '0;
    line_end_next   = 1'b0;
    wake_next       = 1'b0;
    fill            = idx_diff(edit_idx, read_idx);
    wr_char         = (char_q == leib_pkg::CH_CR) ? leib_pkg::CH_LF : char_q;
    if (kind_q == leib_pkg::KIND_RX) begin
      case (char_q) inside
        leib_pkg::CH_NUL, leib_pkg::CH_DUMP: begin
        end
        leib_pkg::CH_KILL: begin
          edit_idx_next = commit_idx;
        end
        leib_pkg::CH_BS, leib_pkg::CH_DEL: begin
          if (edit_idx != commit_idx) edit_idx_next = idx_dec(edit_idx);
        end
        default: begin
          if (fill < DEPTH_I) begin
            store         = 1'b1;
            edit_idx_next = idx_inc(edit_idx);
            if (wr_char == leib_pkg::CH_LF || wr_char == leib_pkg::CH_EOT ||
                fill == DEPTH_LAST) begin
              commit_idx_next = idx_inc(edit_idx);
              wake_next       = 1'b1;
            end
          end
        end
      endcase
    end else if (read_idx == commit_idx) begin
      status_next = leib_pkg::ST_EMPTY;
    end else if (rd_data == leib_pkg::CH_EOT) begin
      status_next = leib_pkg::ST_EOF;
      if (!prog_q) read_idx_next = idx_inc(read_idx);
    end else begin
      read_idx_next = idx_inc(read_idx);
      status_next   = leib_pkg::ST_CHAR;
      data_next     = rd_data;
      line_end_next = (rd_data == leib_pkg::CH_LF);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_q <= kind;
      char_q <= rx_char;
      prog_q <= read_in_progress;
    end
    if (cmd.finish) begin
      status   <= status_next;
      data     <= data_next;
      line_end <= line_end_next;
      wake     <= wake_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_idx   <= '0;
      commit_idx <= '0;
      edit_idx   <= '0;
      out_valid  <= 1'b0;
    end else if (cmd.finish) begin
      read_idx   <= read_idx_next;
      commit_idx <= commit_idx_next;
      edit_idx   <= edit_idx_next;
      out_valid  <= 1'b1;
    end else if (m_tready) begin
      out_valid  <= 1'b0;
    end
  end

endmodule
